>>> rtl/mswt_pkg.sv
// ----------------------------------------------------------------------------
// mswt_pkg: shared constants and types
// Ring geometry, level count and the sequencer states of the throughput meter.
// ----------------------------------------------------------------------------
package mswt_pkg;

  localparam int unsigned BASE_LEN = 16;
  localparam int unsigned LEVELS   = 6;
  localparam int unsigned RING_LEN = BASE_LEN << LEVELS;
  localparam int unsigned RING_AW  = $clog2(RING_LEN);
  localparam int unsigned CNT_W    = RING_AW + 1;
  localparam int unsigned LVL_W    = $clog2(LEVELS + 1);
  localparam int unsigned SUM_W    = 35;
  localparam int unsigned DVD_W    = SUM_W + 5 + 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ADD_WR,
    ST_RAW,
    ST_BKT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> rtl/multiscale_window_throughput_unit.sv
// ----------------------------------------------------------------------------
// multiscale_window_throughput_unit: packet-size throughput meter
// Ring of recent sizes in one RAM plus per-level bucket sums; queries return
// mean size times 800 in unsigned Q.8 over a bucket-rounded window.
// ----------------------------------------------------------------------------
// One request at a time; the ring sits in a 1024x16 RAM with one write port and a
// registered read port, the bucket sums in registers. An add does twelve RAM reads (the
// entering and leaving entry of each of the six buckets) and one write-back.
// A query reads up to 16 newest entries, adds at most six whole buckets, runs a
// bit-serial division for 53 quotient bits and then hands off the result.
// No clearing pass is needed after reset: entries older than the fill count
// read as zero.
module multiscale_window_throughput_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] sample_size, [26:16] window_len
  input  logic        in_tuser,   // op: 0 add, 1 query
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [33:0] throughput_q8, [44:34] samples_used
);

  localparam int unsigned AW  = mswt_pkg::RING_AW;
  localparam int unsigned CW  = mswt_pkg::CNT_W;
  localparam int unsigned LW  = mswt_pkg::LVL_W;
  localparam int unsigned SW  = mswt_pkg::SUM_W;
  localparam int unsigned DW  = mswt_pkg::DVD_W;
  localparam int unsigned NL  = mswt_pkg::LEVELS;

  mswt_pkg::state_t state_r, state_nxt;

  logic [15:0] ring_mem [mswt_pkg::RING_LEN];
  logic [15:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic        mem_we;

  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [31:0]   bkt_r [NL];
  logic [31:0]   bkt_nxt [NL];
  logic [5:0]    cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] pend_lvl_r, pend_lvl_nxt;
  logic          pend_sub_r, pend_sub_nxt;
  logic          pend_ok_r, pend_ok_nxt;
  logic [15:0]   samp_r, samp_nxt;
  logic [CW-1:0] raw_r, raw_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;

  // scratch for the combinational block
  logic [CW-1:0] len, back, wanted;
  logic [CW:0]   rem_ext;
  logic [39:0]   prod;
  logic [15:0]   rd_val;

  assign in_tready  = (state_r == mswt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Ring RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[ptr_r] <= samp_r;
    end
    rdata_r <= ring_mem[rd_addr];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mswt_pkg::ST_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NL; i++) bkt_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NL; i++) bkt_r[i] <= bkt_nxt[i];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    pend_lvl_r <= pend_lvl_nxt;
    pend_sub_r <= pend_sub_nxt;
    pend_ok_r  <= pend_ok_nxt;
    samp_r     <= samp_nxt;
    raw_r      <= raw_nxt;
    need_r     <= need_nxt;
    used_r     <= used_nxt;
    sum_r      <= sum_nxt;
    lvl_r      <= lvl_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_lvl_nxt  = pend_lvl_r;
    pend_sub_nxt  = pend_sub_r;
    pend_ok_nxt   = pend_ok_r;
    samp_nxt      = samp_r;
    raw_nxt       = raw_r;
    need_nxt      = need_r;
    used_nxt      = used_r;
    sum_nxt       = sum_r;
    lvl_nxt       = lvl_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    for (int i = 0; i < NL; i++) bkt_nxt[i] = bkt_r[i];
    mem_we  = 1'b0;
    rd_addr = ptr_r;
    len     = '0;
    back    = '0;
    wanted  = '0;
    rem_ext = '0;
    prod    = '0;
    rd_val  = pend_ok_r ? rdata_r : 16'd0;

    // bucket update from the read issued last cycle
    if (pend_r && (state_r == mswt_pkg::ST_ADD || state_r == mswt_pkg::ST_ADD_WR)) begin
      if (pend_sub_r) bkt_nxt[pend_lvl_r] = bkt_r[pend_lvl_r] - {16'd0, rd_val};
      else            bkt_nxt[pend_lvl_r] = bkt_r[pend_lvl_r] + {16'd0, rd_val};
    end

    case (state_r)
      mswt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt = '0;
          if (!in_tuser) begin
            samp_nxt  = in_tdata[15:0];
            state_nxt = mswt_pkg::ST_ADD;
          end else begin
            wanted   = (in_tdata[26:16] > fill_r) ? fill_r : in_tdata[26:16];
            raw_nxt  = (wanted > CW'(mswt_pkg::BASE_LEN)) ? CW'(mswt_pkg::BASE_LEN) : wanted;
            need_nxt = wanted - raw_nxt;
            used_nxt = raw_nxt;
            sum_nxt  = '0;
            lvl_nxt  = '0;
            state_nxt = mswt_pkg::ST_RAW;
          end
        end
      end

      // read entering and leaving entries, level by level
      mswt_pkg::ST_ADD: begin
        len  = CW'(mswt_pkg::BASE_LEN) << cnt_r[3:1];
        back = cnt_r[0] ? (len << 1) : len;
        rd_addr      = ptr_r - back[AW-1:0];
        pend_nxt     = 1'b1;
        pend_lvl_nxt = LW'(cnt_r[3:1]);
        pend_sub_nxt = cnt_r[0];
        pend_ok_nxt  = (back <= fill_r);
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(2 * NL - 1)) state_nxt = mswt_pkg::ST_ADD_WR;
      end

      mswt_pkg::ST_ADD_WR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if (fill_r != CW'(mswt_pkg::RING_LEN)) fill_nxt = fill_r + CW'(1);
        state_nxt = mswt_pkg::ST_IDLE;
      end

      // sum the newest raw entries
      mswt_pkg::ST_RAW: begin
        if (pend_r) sum_nxt = sum_r + SW'(rdata_r);
        if (CW'(cnt_r) != raw_r) begin
          rd_addr  = ptr_r - AW'(cnt_r + 6'd1);
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 6'd1;
        end else if (!pend_r) begin
          state_nxt = mswt_pkg::ST_BKT;
        end
      end

      // add whole buckets until the window is covered or the levels run out
      mswt_pkg::ST_BKT: begin
        len = CW'(mswt_pkg::BASE_LEN) << lvl_r;
        if (need_r != '0 && lvl_r < LW'(NL)) begin
          sum_nxt  = sum_r + SW'(bkt_r[lvl_r]);
          used_nxt = used_r + len;
          need_nxt = (need_r > len) ? need_r - len : '0;
          lvl_nxt  = lvl_r + LW'(1);
        end else begin
          if (used_r > fill_r) used_nxt = fill_r;
          // sum * 800 * 256 = (sum * 25) << 13
          prod    = ({5'd0, sum_r} << 4) + ({5'd0, sum_r} << 3) + {5'd0, sum_r};
          dvd_nxt = {prod, 13'd0};
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = mswt_pkg::ST_DIV;
        end
      end

      // restoring division, one quotient bit per cycle
      mswt_pkg::ST_DIV: begin
        rem_ext = {rem_r, dvd_r[DW-1]};
        dvd_nxt = dvd_r << 1;
        if (rem_ext >= {1'b0, used_r}) begin
          rem_nxt = CW'(rem_ext - {1'b0, used_r});
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_ext[CW-1:0];
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DW - 1)) state_nxt = mswt_pkg::ST_OUT;
      end

      mswt_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, used_r,
                           (used_r == '0) ? 34'd0 : quo_r[33:0]};
          state_nxt     = mswt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mswt_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> verif/tb_multiscale_window_throughput_unit.sv
// ----------------------------------------------------------------------------
// tb_multiscale_window_throughput_unit: self-checking bench for the meter
// Drives add and query requests with random gaps, predicts every query result
// from a local model of the ring and bucket sums, and compares field by field.
// ----------------------------------------------------------------------------
module tb_multiscale_window_throughput_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int   IDLE_LIMIT = 4000;

  typedef struct packed {
    logic        op;
    logic [15:0] size;
    logic [10:0] window;
  } meter_req_t;

  typedef struct packed {
    logic [33:0] rate_q8;
    logic [10:0] used;
  } meter_rsp_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;

  multiscale_window_throughput_unit dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // local copy of meter state
  logic [15:0] ring_q [mswt_pkg::RING_LEN];
  logic [31:0] bucket_q [mswt_pkg::LEVELS];
  int unsigned wr_idx, fill_cnt;

  meter_req_t pending_reqs[$];
  meter_rsp_t expected_rates[$];
  int  errors = 0;
  bit  hold_sender = 0;
  bit  in_fire = 0;
  int  idle_cycles = 0;

  function automatic int unsigned back_idx(int unsigned back);
    return (wr_idx + mswt_pkg::RING_LEN - back) % mswt_pkg::RING_LEN;
  endfunction

  // apply one request to the model; queries push an expected result
  function automatic void predict_meter(meter_req_t r);
    int unsigned len, wanted, raw, need, used;
    logic [63:0] sum, q8;
    if (r.op == OP_ADD) begin
      for (int i = 0; i < mswt_pkg::LEVELS; i++) begin
        len = mswt_pkg::BASE_LEN << i;
        bucket_q[i] = bucket_q[i] + ring_q[back_idx(len)] - ring_q[back_idx(2 * len)];
      end
      ring_q[wr_idx] = r.size;
      wr_idx = (wr_idx + 1) % mswt_pkg::RING_LEN;
      if (fill_cnt < mswt_pkg::RING_LEN) fill_cnt++;
    end else begin
      wanted = (r.window > fill_cnt) ? fill_cnt : r.window;
      raw = (wanted > mswt_pkg::BASE_LEN) ? mswt_pkg::BASE_LEN : wanted;
      need = wanted - raw;
      used = raw;
      sum = 0;
      q8 = 0;
      for (int i = 1; i <= raw; i++) sum += ring_q[back_idx(i)];
      for (int i = 0; need != 0 && i < mswt_pkg::LEVELS; i++) begin
        len = mswt_pkg::BASE_LEN << i;
        sum += bucket_q[i];
        used += len;
        need = (need > len) ? need - len : 0;
      end
      if (used > fill_cnt) used = fill_cnt;
      if (used != 0) q8 = (sum * 800 * 256) / used;
      expected_rates.push_back('{rate_q8: q8[33:0], used: used[10:0]});
    end
  endfunction

  // driver: one request at a time, random gap after each
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold request until it is taken
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0 && !hold_sender) begin
      meter_req_t r;
      r = pending_reqs.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= r.op;
      in_tdata  <= {5'd0, r.window, r.size};
      send_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver stall
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_tvalid && in_tready) begin
        predict_meter('{op: in_tuser, size: in_tdata[15:0], window: in_tdata[26:16]});
      end
      if (out_tvalid && out_tready) begin
        if (expected_rates.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          errors++;
        end else begin
          meter_rsp_t e;
          e = expected_rates.pop_front();
          if (out_tdata[33:0] !== e.rate_q8) begin
            $error("throughput_q8 expected %0d actual %0d", e.rate_q8, out_tdata[33:0]);
            errors++;
          end
          if (out_tdata[44:34] !== e.used) begin
            $error("samples_used expected %0d actual %0d", e.used, out_tdata[44:34]);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_req(logic op, logic [15:0] size, logic [10:0] window);
    pending_reqs.push_back('{op: op, size: size, window: window});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_rates.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    int n, wl;
    in_tvalid = 1'b0;
    in_tuser = OP_ADD;
    in_tdata = '0;
    out_tready = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < mswt_pkg::RING_LEN; i++) ring_q[i] = '0;
    for (int i = 0; i < mswt_pkg::LEVELS; i++) bucket_q[i] = '0;
    wr_idx = 0;
    fill_cnt = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty meter, zero window, extremes, window past fill count
    push_req(OP_QUERY, 16'h0, 11'd0);
    push_req(OP_QUERY, 16'hffff, 11'd1024);
    push_req(OP_ADD, 16'hffff, 11'h7ff);
    push_req(OP_ADD, 16'h0, 11'd0);
    push_req(OP_QUERY, 16'h0, 11'd1);
    push_req(OP_QUERY, 16'h0, 11'd1024);
    push_req(OP_QUERY, 16'h0, 11'h7ff);
    for (int i = 0; i < 14; i++) push_req(OP_ADD, 16'hffff, 11'd0);
    push_req(OP_QUERY, 16'h0, 11'd16);
    push_req(OP_QUERY, 16'h0, 11'd17);
    push_req(OP_QUERY, 16'h0, 11'd5);

    // wait until every request is sent and every result is back
    wait_drained();

    // random: mostly adds (to fill and wrap the ring), queries of all sizes
    for (int k = 0; k < 60; k++) begin
      n = $urandom_range(0, 9);
      if (n < 7) begin
        n = $urandom_range(0, 7);
        push_req(OP_ADD, (n == 0) ? 16'hffff : (n == 1) ? 16'h0 : 16'($urandom),
                 11'($urandom));
      end else begin
        n = $urandom_range(0, 5);
        wl = (n == 0) ? 1024 : (n == 1) ? $urandom_range(0, 2047) :
             (n == 2) ? $urandom_range(0, 16) : $urandom_range(0, 1024);
        push_req(OP_QUERY, 16'($urandom), 11'(wl));
      end
      if (k == 10) begin
        // fill past the ring size with queries along the way, then query at full extent
        for (int j = 0; j < 1030; j++) begin
          push_req(OP_ADD, 16'($urandom), 11'd0);
          if (j % 32 == 31) push_req(OP_QUERY, 16'h0, 11'($urandom_range(0, 1024)));
        end
        push_req(OP_QUERY, 16'h0, 11'd1024);
        push_req(OP_QUERY, 16'h0, 11'd1000);
      end
    end
    push_req(OP_QUERY, 16'h0, 11'd1024);
    push_req(OP_QUERY, 16'hffff, 11'h7ff);

    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mswt_pkg.sv
rtl/multiscale_window_throughput_unit.sv
verif/tb_multiscale_window_throughput_unit.sv
